// File: design/rspm_pkg.sv
// rspm_pkg: shared types, codes and field widths of the route sensor progress monitor
// depends on nothing; used by every design file through scoped names
package rspm_pkg;

   // default route table depth
   localparam int ROUTE_DEPTH_DEF = 256;

   // stream widths
   localparam int REQ_DATA_W = 88;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // field widths
   localparam int OFF_W  = 8;
   localparam int NODE_W = 8;
   localparam int DIST_W = 20;
   localparam int SEQ_W  = 32;
   localparam int LEN_W  = 9;
   localparam int MEM_W  = DIST_W + NODE_W + 1 + NODE_W;

   // request kinds carried in tuser
   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_EVENT = 2'd2;

   // result classification codes
   localparam logic [1:0] CLS_NORMAL    = 2'd0;
   localparam logic [1:0] CLS_MISSING   = 2'd1;
   localparam logic [1:0] CLS_SPURIOUS  = 2'd2;
   localparam logic [1:0] CLS_DUPLICATE = 2'd3;

   // register indexes on the csr channel
   localparam logic [1:0] REG_ORIGIN   = 2'd0;
   localparam logic [1:0] REG_TERMINAL = 2'd1;
   localparam logic [1:0] REG_LENGTH   = 2'd2;
   localparam logic [1:0] REG_BASE_SEQ = 2'd3;

   // "none" markers of the signed result fields
   localparam logic [8:0]  NONE9  = 9'h1FF;
   localparam logic [20:0] NONE21 = 21'h1FFFFF;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic scan_init;
      logic scan;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_scan;
      logic scan_done;
      logic slot_free;
   } sts_type;

endpackage

// File: design/rspm_ctrl.sv
// rspm_ctrl: sequencing state machine of the monitor (idle, table scan, result)
// depends on rspm_pkg for the state type and the command and status structs
module rspm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  rspm_pkg::sts_type sts,
   output rspm_pkg::cmd_type cmd
);

   rspm_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rspm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd.accept    = 1'b0;
      cmd.scan_init = 1'b0;
      cmd.scan      = 1'b0;
      cmd.finish    = 1'b0;
      unique case (state_ff)
         rspm_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept    = 1'b1;
               cmd.scan_init = sts.need_scan;
               state_in      = sts.need_scan ? rspm_pkg::S_SCAN : rspm_pkg::S_RESP;
            end
         end
         rspm_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = rspm_pkg::S_RESP;
            end
         end
         rspm_pkg::S_RESP: begin
            if (sts.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = rspm_pkg::S_IDLE;
            end
         end
         default: state_in = rspm_pkg::S_IDLE;
      endcase
   end

endmodule

// File: design/rspm_dp.sv
// rspm_dp: route table memory, monitor state, scan datapath and result register
// depends on rspm_pkg; driven by rspm_ctrl through cmd_type and sts_type
module rspm_dp #(
   parameter int ROUTE_DEPTH = rspm_pkg::ROUTE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rspm_pkg::cmd_type                  cmd,
   output rspm_pkg::sts_type                  sts,
   input  logic [rspm_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [rspm_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic                               csr_valid,
   input  logic [rspm_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [rspm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rspm_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int AW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;

   // request fields
   logic [7:0]  in_off, in_node, in_rev, in_snode;
   logic        in_flag;
   logic [19:0] in_dist;
   logic [31:0] in_seq;
   assign in_off   = req_tdata[7:0];
   assign in_node  = req_tdata[15:8];
   assign in_flag  = req_tdata[16];
   assign in_rev   = req_tdata[24:17];
   assign in_dist  = req_tdata[44:25];
   assign in_snode = req_tdata[52:45];
   assign in_seq   = req_tdata[84:53];

   // configuration registers
   logic [7:0]  orig_ff, term_ff;
   logic [8:0]  len_ff;
   logic [31:0] base_seq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         orig_ff     <= '0;
         term_ff     <= '0;
         len_ff      <= 9'd1;
         base_seq_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_addr)
            rspm_pkg::REG_ORIGIN:   orig_ff     <= csr_wdata[7:0];
            rspm_pkg::REG_TERMINAL: term_ff     <= csr_wdata[7:0];
            rspm_pkg::REG_LENGTH:   len_ff      <= csr_wdata[8:0];
            rspm_pkg::REG_BASE_SEQ: base_seq_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // monitor state
   logic [7:0]  cp_ff, mterm_ff;
   logic [19:0] cmm_ff;
   logic [31:0] last_ff;
   logic        missed_ff, started_ff;

   // request checks done at accept time
   logic len_ok, start_bad, evt_bad, load_bad, pre_err, need_scan;
   always_comb begin
      len_ok    = (len_ff != 9'd0) && (32'(len_ff) <= ROUTE_DEPTH);
      start_bad = !len_ok || (term_ff < orig_ff) || ({1'b0, term_ff} >= len_ff);
      evt_bad   = !started_ff || !len_ok || ({1'b0, mterm_ff} >= len_ff) ||
                  (cp_ff > mterm_ff) || (in_seq == 32'd0);
      load_bad  = 32'(in_off) >= ROUTE_DEPTH;
      unique case (req_tuser)
         rspm_pkg::FUNC_LOAD: begin
            pre_err   = load_bad;
            need_scan = 1'b0;
         end
         rspm_pkg::FUNC_START: begin
            pre_err   = start_bad;
            need_scan = !start_bad;
         end
         rspm_pkg::FUNC_EVENT: begin
            pre_err   = evt_bad;
            need_scan = !evt_bad;
         end
         default: begin
            pre_err   = 1'b1;
            need_scan = 1'b0;
         end
      endcase
   end

   // request latch
   logic [1:0]  op_ff;
   logic        err_ff;
   logic [7:0]  snode_ff;
   logic [31:0] seq_ff;
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_tuser;
         err_ff   <= pre_err;
         snode_ff <= in_snode;
         seq_ff   <= in_seq;
      end
   end

   // route table memory: {distance, reverse, sensor flag, node}
   logic [rspm_pkg::MEM_W-1:0] mem [ROUTE_DEPTH];
   logic [rspm_pkg::MEM_W-1:0] rd_data_ff;
   logic [AW-1:0]              rd_addr;

   // scan pointer and bounds
   logic [8:0] ptr_ff;
   logic [7:0] end_ff, base_ff;
   logic       issue;
   logic       rd_vld_ff;
   logic [7:0] rd_off_ff;

   assign issue   = cmd.scan && (ptr_ff <= {1'b0, end_ff});
   assign rd_addr = AW'(ptr_ff[7:0]);

   always_ff @(posedge clock) begin
      if (cmd.accept && (req_tuser == rspm_pkg::FUNC_LOAD) && !load_bad) begin
         mem[AW'(in_off)] <= {in_dist, in_rev, in_flag, in_node};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      rd_off_ff <= ptr_ff[7:0];
      if (cmd.scan_init) begin
         ptr_ff  <= (req_tuser == rspm_pkg::FUNC_START) ? {1'b0, orig_ff} : {1'b0, cp_ff};
         end_ff  <= (req_tuser == rspm_pkg::FUNC_START) ? term_ff : mterm_ff;
         base_ff <= (req_tuser == rspm_pkg::FUNC_START) ? orig_ff : cp_ff;
      end else if (issue) begin
         ptr_ff <= ptr_ff + 9'd1;
      end
   end

   // returned entry
   logic [7:0]  q_node, q_rev;
   logic        q_flag;
   logic [19:0] q_dist;
   assign q_node = rd_data_ff[7:0];
   assign q_flag = rd_data_ff[8];
   assign q_rev  = rd_data_ff[16:9];
   assign q_dist = rd_data_ff[36:17];

   // scan checks on each returned entry
   logic       q_act, q_base, q_start, hit_fail, capture;
   logic [1:0] cnt_ff;
   logic       fail_ff;
   logic [7:0] prev_rev_ff;
   logic [19:0] start_mm_ff;
   logic [7:0]  exp_off_ff  [2];
   logic [7:0]  exp_node_ff [2];
   logic [7:0]  exp_rev_ff  [2];
   logic [19:0] exp_dist_ff [2];

   always_comb begin
      q_act    = cmd.scan && rd_vld_ff;
      q_base   = rd_off_ff == base_ff;
      q_start  = op_ff == rspm_pkg::FUNC_START;
      hit_fail = q_act && (q_start ? (!q_base && (prev_rev_ff == q_node))
                                   : (q_base && (q_dist != cmm_ff)));
      capture  = q_act && !q_start && !q_base && q_flag && (cnt_ff != 2'd2);
   end

   assign sts.need_scan = need_scan;
   assign sts.scan_done = rd_vld_ff &&
                          ((rd_off_ff == end_ff) || hit_fail || (capture && (cnt_ff == 2'd1)));

   // count and fail flag start fresh with every accepted beat
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cnt_ff  <= 2'd0;
         fail_ff <= 1'b0;
      end else begin
         if (hit_fail) begin
            fail_ff <= 1'b1;
         end
         if (capture) begin
            cnt_ff                 <= cnt_ff + 2'd1;
            exp_off_ff[cnt_ff[0]]  <= rd_off_ff;
            exp_node_ff[cnt_ff[0]] <= q_node;
            exp_rev_ff[cnt_ff[0]]  <= q_rev;
            exp_dist_ff[cnt_ff[0]] <= q_dist;
         end
      end
      if (q_act && q_start) begin
         prev_rev_ff <= q_rev;
         if (q_base) begin
            start_mm_ff <= q_dist;
         end
      end
   end

   // result and state update
   logic        o_status;
   logic [1:0]  o_cls;
   logic [8:0]  o_eo, o_en, o_eno, o_enn, o_mo, o_mis;
   logic [20:0] o_md;
   logic [19:0] o_adv;
   logic        do_start, do_seq, do_missed, do_conf;
   logic        newer, match0, match1, dec;
   logic [31:0] seq_diff;
   logic [7:0]  m_off;
   logic [19:0] m_dist;

   always_comb begin
      seq_diff = seq_ff - last_ff;
      newer    = (seq_ff != last_ff) && ((last_ff == 32'd0) || !seq_diff[31]);
      match0   = (cnt_ff != 2'd0) &&
                 ((exp_node_ff[0] == snode_ff) || (exp_rev_ff[0] == snode_ff));
      match1   = (cnt_ff == 2'd2) && !missed_ff &&
                 ((exp_node_ff[1] == snode_ff) || (exp_rev_ff[1] == snode_ff));
      m_off    = match0 ? exp_off_ff[0] : exp_off_ff[1];
      m_dist   = match0 ? exp_dist_ff[0] : exp_dist_ff[1];
      dec      = m_dist < cmm_ff;

      o_status  = 1'b0;
      o_cls     = rspm_pkg::CLS_NORMAL;
      o_eo      = rspm_pkg::NONE9;
      o_en      = rspm_pkg::NONE9;
      o_eno     = rspm_pkg::NONE9;
      o_enn     = rspm_pkg::NONE9;
      o_mo      = rspm_pkg::NONE9;
      o_md      = rspm_pkg::NONE21;
      o_mis     = rspm_pkg::NONE9;
      o_adv     = '0;
      do_start  = 1'b0;
      do_seq    = 1'b0;
      do_missed = 1'b0;
      do_conf   = 1'b0;

      if (err_ff && (op_ff == rspm_pkg::FUNC_LOAD)) begin
         // load beyond the table keeps the normal class
         o_status = 1'b1;
      end else if (err_ff || fail_ff) begin
         o_status = 1'b1;
         o_cls    = rspm_pkg::CLS_SPURIOUS;
      end else if (op_ff == rspm_pkg::FUNC_START) begin
         do_start = 1'b1;
      end else if (op_ff == rspm_pkg::FUNC_EVENT) begin
         o_cls = rspm_pkg::CLS_SPURIOUS;
         if (cnt_ff != 2'd0) begin
            o_eo = {1'b0, exp_off_ff[0]};
            o_en = {1'b0, exp_node_ff[0]};
         end
         if (cnt_ff == 2'd2) begin
            o_eno = {1'b0, exp_off_ff[1]};
            o_enn = {1'b0, exp_node_ff[1]};
         end
         if (!newer) begin
            o_cls = rspm_pkg::CLS_DUPLICATE;
         end else begin
            do_seq = 1'b1;
            if (match0 || match1) begin
               do_missed = !match0;
               if (dec) begin
                  o_status = 1'b1;
                  o_eo     = rspm_pkg::NONE9;
                  o_en     = rspm_pkg::NONE9;
                  o_eno    = rspm_pkg::NONE9;
                  o_enn    = rspm_pkg::NONE9;
               end else begin
                  do_conf = 1'b1;
                  o_cls   = match0 ? rspm_pkg::CLS_NORMAL : rspm_pkg::CLS_MISSING;
                  o_mis   = match0 ? rspm_pkg::NONE9 : {1'b0, exp_off_ff[0]};
                  o_mo    = {1'b0, m_off};
                  o_md    = {1'b0, m_dist};
                  o_adv   = m_dist - cmm_ff;
               end
            end
         end
      end
   end

   // monitor state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff      <= '0;
         mterm_ff   <= '0;
         cmm_ff     <= '0;
         last_ff    <= '0;
         missed_ff  <= 1'b0;
         started_ff <= 1'b0;
      end else if (cmd.finish) begin
         if (do_start) begin
            cp_ff      <= orig_ff;
            mterm_ff   <= term_ff;
            cmm_ff     <= start_mm_ff;
            last_ff    <= base_seq_ff;
            missed_ff  <= 1'b0;
            started_ff <= 1'b1;
         end
         if (do_seq) begin
            last_ff <= seq_ff;
         end
         if (do_missed) begin
            missed_ff <= 1'b1;
         end
         if (do_conf) begin
            cp_ff  <= m_off;
            cmm_ff <= m_dist;
         end
      end
   end

   // output register
   logic                            rsp_valid_ff;
   logic [rspm_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   assign sts.slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= {6'd0, o_adv, o_mis, o_md, o_mo, o_enn, o_eno, o_en, o_eo,
                         o_cls, o_status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: design/route_sensor_progress_monitor_top.sv
// route_sensor_progress_monitor_top: top level, joins controller and datapath
// depends on rspm_pkg, rspm_ctrl and rspm_dp
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   req_tdata 88b, req_tuser 2b (kind)
//   rsp      out        rsp_tvalid/rsp_tready   rsp_tdata 104b
//   csr      in         csr_valid/csr_ready     csr_addr 2b, csr_wdata 32b
//
// a load goes from accept straight to the result state, which writes the output register
// a start scans the route table from origin up to terminal, one route table read per cycle
// an event scans from the confirmed position up to the terminal; the scan stops after two sensors
// one item in work at a time; the output register lets the next item in while a result waits
// a full output register that is not taken holds the item in its last cycle
// reset clears monitor state and config; the route table holds no reset and needs no pass
module route_sensor_progress_monitor_top #(
   parameter int ROUTE_DEPTH = rspm_pkg::ROUTE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entry_offset, entry_node, entry_is_sensor, entry_reverse, entry_distance,
   // observed sensor id, event seq number, zero fill
   input  logic [rspm_pkg::REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [rspm_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status, classification, expected_offset, expected_node, expected_next_offset,
   // expected_next_node, matched_offset, matched_distance, missing_offset,
   // gain in mm, zero fill
   output logic [rspm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rspm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rspm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   rspm_pkg::cmd_type cmd;
   rspm_pkg::sts_type sts;

   // register writes are always taken
   assign csr_ready = 1'b1;

   rspm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rspm_dp #(
      .ROUTE_DEPTH (ROUTE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: design/rspm_checker.sv
// rspm_checker: port level checks of the monitor, bound to the top level
// depends on rspm_pkg and route_sensor_progress_monitor_top
module rspm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [rspm_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rspm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // one item at a time: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // a load into an empty output register shows up once the result state has written it
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid && (req_tuser == rspm_pkg::FUNC_LOAD)
      |=> ##1 rsp_tvalid)
      else $error("load result late");

   // duplicates never report an error
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:1] == rspm_pkg::CLS_DUPLICATE) |-> !rsp_tdata[0])
      else $error("duplicate with error status");

endmodule

bind route_sensor_progress_monitor_top rspm_checker u_rspm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: test/tb_route_sensor_progress_monitor_top.sv
// tb_route_sensor_progress_monitor_top: self-checking bench for the route sensor progress monitor
// depends on rspm_pkg and route_sensor_progress_monitor_top; keeps its own model of the
// route table and the monitor, and checks every response beat against it
module tb_route_sensor_progress_monitor_top;

   localparam int DEPTH      = 256;
   localparam int IDLE_LIMIT = 20000;
   localparam int ITEM_STOP  = 600;
   localparam logic [31:0] SEQ_HALF = 32'h8000_0000;
   // request kind the block does not know
   localparam logic [1:0] FUNC_BAD = 2'd3;

   // response fields, status in the lowest bit
   typedef struct packed {
      logic [19:0] gain_mm;
      logic [8:0]  missing_offset;
      logic [20:0] matched_distance;
      logic [8:0]  matched_offset;
      logic [8:0]  exp_next_node;
      logic [8:0]  exp_next_offset;
      logic [8:0]  exp_node;
      logic [8:0]  exp_offset;
      logic [1:0]  cls;
      logic        status;
   } outcome_type;

   typedef struct {
      logic [1:0]  func;
      logic [87:0] data;
      outcome_type outcome;
   } request_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [rspm_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [rspm_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [rspm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic [rspm_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [rspm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   route_sensor_progress_monitor_top uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // model of route table, registers and monitor state
   logic [7:0]  tbl_node [DEPTH];
   logic [7:0]  tbl_rev [DEPTH];
   logic        tbl_sensor [DEPTH];
   logic [19:0] tbl_dist [DEPTH];
   logic [7:0]  cfg_origin = 0, cfg_terminal = 0;
   logic [8:0]  cfg_length = 1;
   logic [31:0] cfg_base_seq = 0;
   logic [7:0]  conf_pos = 0, mon_terminal = 0;
   logic [19:0] conf_mm = 0;
   logic [31:0] last_seq = 0;
   logic        missed_one = 0, mon_started = 0;

   request_type pending_q[$];
   outcome_type awaited_q[$];
   int send_idle = 0, recv_stall = 0;
   int errors = 0, items_pushed = 0, quiet_cycles = 0;

   function automatic outcome_type blank_outcome(logic [1:0] cls, logic status);
      outcome_type r;
      r.status = status;
      r.cls = cls;
      r.exp_offset = rspm_pkg::NONE9;
      r.exp_node = rspm_pkg::NONE9;
      r.exp_next_offset = rspm_pkg::NONE9;
      r.exp_next_node = rspm_pkg::NONE9;
      r.matched_offset = rspm_pkg::NONE9;
      r.matched_distance = rspm_pkg::NONE21;
      r.missing_offset = rspm_pkg::NONE9;
      r.gain_mm = '0;
      return r;
   endfunction

   // first two sensors after the confirmed position, up to the latched terminal
   function automatic int next_sensors(output logic [7:0] s0, output logic [7:0] s1);
      int cnt;
      cnt = 0;
      s0 = 0;
      s1 = 0;
      for (int o = int'(conf_pos) + 1; o <= int'(mon_terminal) && cnt < 2; o++) begin
         if (tbl_sensor[o]) begin
            if (cnt == 0) s0 = o[7:0];
            else s1 = o[7:0];
            cnt++;
         end
      end
      return cnt;
   endfunction

   function automatic logic seq_is_newer(logic [31:0] cand, logic [31:0] ref_seq);
      logic [31:0] diff;
      diff = cand - ref_seq;
      if (cand == 0 || cand == ref_seq) return 0;
      if (ref_seq == 0) return 1;
      return diff < SEQ_HALF;
   endfunction

   function automatic logic length_valid();
      return cfg_length >= 1 && cfg_length <= DEPTH;
   endfunction

   // expected response of one request, updates the model state
   function automatic outcome_type progress_predict(logic [1:0] func, logic [87:0] d);
      outcome_type r;
      logic [7:0] s0, s1, m, sensor;
      logic [31:0] seq;
      int cnt;
      logic hit;
      sensor = d[52:45];
      seq = d[84:53];
      case (func)
         rspm_pkg::FUNC_LOAD: begin
            tbl_node[d[7:0]] = d[15:8];
            tbl_sensor[d[7:0]] = d[16];
            tbl_rev[d[7:0]] = d[24:17];
            tbl_dist[d[7:0]] = d[44:25];
            return blank_outcome(rspm_pkg::CLS_NORMAL, 0);
         end
         rspm_pkg::FUNC_START: begin
            if (!length_valid() || cfg_terminal < cfg_origin || cfg_terminal >= cfg_length)
               return blank_outcome(rspm_pkg::CLS_SPURIOUS, 1);
            for (int o = cfg_origin; o < cfg_terminal; o++)
               if (tbl_rev[o] == tbl_node[o + 1])
                  return blank_outcome(rspm_pkg::CLS_SPURIOUS, 1);
            mon_terminal = cfg_terminal;
            conf_pos = cfg_origin;
            conf_mm = tbl_dist[cfg_origin];
            last_seq = cfg_base_seq;
            missed_one = 0;
            mon_started = 1;
            return blank_outcome(rspm_pkg::CLS_NORMAL, 0);
         end
         rspm_pkg::FUNC_EVENT: begin
            if (!mon_started || !length_valid() || mon_terminal >= cfg_length ||
                conf_pos > mon_terminal || tbl_dist[conf_pos] != conf_mm || seq == 0)
               return blank_outcome(rspm_pkg::CLS_SPURIOUS, 1);
            cnt = next_sensors(s0, s1);
            r = blank_outcome(rspm_pkg::CLS_SPURIOUS, 0);
            if (cnt >= 1) begin
               r.exp_offset = {1'b0, s0};
               r.exp_node = {1'b0, tbl_node[s0]};
            end
            if (cnt >= 2) begin
               r.exp_next_offset = {1'b0, s1};
               r.exp_next_node = {1'b0, tbl_node[s1]};
            end
            if (!seq_is_newer(seq, last_seq)) begin
               r.cls = rspm_pkg::CLS_DUPLICATE;
               return r;
            end
            last_seq = seq;
            hit = 0;
            if (cnt >= 1 && (tbl_node[s0] == sensor || tbl_rev[s0] == sensor)) begin
               m = s0;
               r.cls = rspm_pkg::CLS_NORMAL;
               hit = 1;
            end else if (cnt >= 2 && (tbl_node[s1] == sensor || tbl_rev[s1] == sensor) &&
                         !missed_one) begin
               m = s1;
               r.cls = rspm_pkg::CLS_MISSING;
               r.missing_offset = {1'b0, s0};
               missed_one = 1;
               hit = 1;
            end
            if (!hit) return r;
            if (tbl_dist[m] < conf_mm) return blank_outcome(rspm_pkg::CLS_SPURIOUS, 1);
            r.matched_offset = {1'b0, m};
            r.matched_distance = {1'b0, tbl_dist[m]};
            r.gain_mm = tbl_dist[m] - conf_mm;
            conf_pos = m;
            conf_mm = tbl_dist[m];
            return r;
         end
         default: return blank_outcome(rspm_pkg::CLS_SPURIOUS, 1);
      endcase
   endfunction

   function automatic void push_request(logic [1:0] func, logic [87:0] d);
      request_type it;
      it.func = func;
      it.data = d;
      it.outcome = progress_predict(func, d);
      pending_q.push_back(it);
      items_pushed++;
   endfunction

   function automatic void push_load(int off, logic [7:0] node, logic sensor,
                                     logic [7:0] rev, logic [19:0] mm);
      logic [87:0] d;
      d = '0;
      d[7:0] = off[7:0];
      d[15:8] = node;
      d[16] = sensor;
      d[24:17] = rev;
      d[44:25] = mm;
      push_request(rspm_pkg::FUNC_LOAD, d);
   endfunction

   function automatic void push_event(logic [7:0] sensor, logic [31:0] seq);
      logic [87:0] d;
      d = '0;
      d[52:45] = sensor;
      d[84:53] = seq;
      push_request(rspm_pkg::FUNC_EVENT, d);
   endfunction

   function automatic logic [87:0] random_payload();
      return {8'h00, 16'($urandom()), $urandom(), $urandom()};
   endfunction

   // block idle: nothing queued, nothing in flight, all responses back
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_q.size() != 0 || awaited_q.size() != 0 || req_tvalid);
      repeat (8) @(posedge clock);
   endtask

   // one register beat; the caller drops csr_valid after the last one
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_valid <= 1;
      csr_addr <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         rspm_pkg::REG_ORIGIN:   cfg_origin = value[7:0];
         rspm_pkg::REG_TERMINAL: cfg_terminal = value[7:0];
         rspm_pkg::REG_LENGTH:   cfg_length = value[8:0];
         rspm_pkg::REG_BASE_SEQ: cfg_base_seq = value;
         default: ;
      endcase
   endtask

   task automatic write_all(int org, int term, int len, logic [31:0] base);
      wait_drained();
      write_reg(rspm_pkg::REG_ORIGIN, org);
      write_reg(rspm_pkg::REG_TERMINAL, term);
      write_reg(rspm_pkg::REG_LENGTH, len);
      write_reg(rspm_pkg::REG_BASE_SEQ, base);
      csr_valid <= 0;
   endtask

   // route segment: nodes below 128, reverse is node with top bit set; corrupt breaks the first link
   task automatic build_route(int org, int span, logic corrupt);
      logic [19:0] run_mm;
      logic [7:0] node, prev_rev;
      run_mm = 20'($urandom_range(0, 20'h7FFFF));
      prev_rev = 0;
      for (int k = org; k <= org + span; k++) begin
         node = {1'b0, 7'($urandom())};
         if (corrupt && k == org + 1) node = prev_rev;
         push_load(k, node, $urandom_range(99) < 50, node | 8'h80, run_mm);
         prev_rev = node | 8'h80;
         if ($urandom_range(99) < 3 && run_mm > 100)
            run_mm = run_mm - 20'($urandom_range(1, 100));
         else
            run_mm = run_mm + 20'($urandom_range(0, 2000));
      end
   endtask

   // one sensor event aimed mostly at the expected sensors
   task automatic random_event();
      logic [7:0] s0, s1, sensor;
      logic [31:0] seq;
      int cnt, pick;
      cnt = next_sensors(s0, s1);
      pick = $urandom_range(99);
      sensor = 8'($urandom());
      if (pick < 45 && cnt >= 1) sensor = $urandom_range(1) ? tbl_node[s0] : tbl_rev[s0];
      else if (pick < 62 && cnt >= 2) sensor = $urandom_range(1) ? tbl_node[s1] : tbl_rev[s1];
      pick = $urandom_range(99);
      if (pick < 80) seq = last_seq + $urandom_range(1, 3);
      else if (pick < 88) seq = last_seq - $urandom_range(0, 5);
      else if (pick < 92) seq = 0;
      else if (pick < 96) seq = last_seq + SEQ_HALF - $urandom_range(0, 1);
      else seq = $urandom();
      push_event(sensor, seq);
   endtask

   task automatic route_run();
      int org, span, term, len, pick;
      logic [31:0] base;
      org = $urandom_range(9) == 0 ? 0 : $urandom_range(0, 230);
      span = $urandom_range(9) == 0 ? $urandom_range(1, 255 - org) : $urandom_range(1, 24);
      if (org + span > 255) span = 255 - org;
      term = org + span;
      wait_drained();
      build_route(org, span, $urandom_range(99) < 8);
      pick = $urandom_range(99);
      if (pick < 85) len = $urandom_range(term + 1, 256);
      else if (pick < 90) len = 0;
      else if (pick < 95) len = term;
      else len = $urandom_range(257, 511);
      pick = $urandom_range(3);
      base = pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF_FFFF - $urandom_range(0, 15) : $urandom();
      if ($urandom_range(99) < 5) write_all(term, org, len, base);
      else write_all(org, term, len, base);
      push_request(rspm_pkg::FUNC_START, random_payload());
      repeat ($urandom_range(6, 16)) begin
         pick = $urandom_range(99);
         if (pick < 3) push_request(FUNC_BAD, random_payload());
         else if (pick < 6) push_load($urandom_range(org, term), 8'($urandom()),
                                     1'($urandom_range(1)), 8'($urandom()),
                                     20'($urandom()));
         else random_event();
      end
   endtask

   // stimulus
   initial begin
      logic [7:0] s0, s1;
      int cnt, phase, first_item;
      repeat (4) @(posedge clock);
      reset <= 0;

      // whole table gets random contents, so no read ever hits an unwritten entry
      for (int k = 0; k < DEPTH; k++)
         push_load(k, 8'($urandom()), 1'($urandom_range(1)), 8'($urandom()),
                   20'($urandom()));

      // event before any start, unknown request kind
      push_event(8'h05, 32'h1);
      push_request(FUNC_BAD, random_payload());
      // start refused: terminal before origin, zero length, terminal past length
      write_all(10, 5, 256, 0);
      push_request(rspm_pkg::FUNC_START, '0);
      write_all(0, 0, 0, 0);
      push_request(rspm_pkg::FUNC_START, '0);
      write_all(0, 8, 8, 0);
      push_request(rspm_pkg::FUNC_START, '0);
      // sequence wrap, normal, missing, duplicate, zero sequence, second miss refused
      wait_drained();
      build_route(0, 12, 0);
      write_all(0, 12, 256, 32'hFFFF_FFFE);
      push_request(rspm_pkg::FUNC_START, '0);
      cnt = next_sensors(s0, s1);
      push_event(tbl_node[s0], 32'hFFFF_FFFF);
      cnt = next_sensors(s0, s1);
      push_event(tbl_rev[s1], 32'h1);
      push_event(tbl_node[s0], 32'h1);
      push_event(tbl_node[s0], 32'h0);
      cnt = next_sensors(s0, s1);
      push_event(tbl_node[s1], 32'h2);
      push_event(8'hFF, 32'h3);
      // extreme offsets: origin and terminal both at the last entry
      write_all(255, 255, 256, 32'h7FFF_FFFF);
      push_request(rspm_pkg::FUNC_START, '0);
      push_event(8'h00, 32'hFFFF_FFFF);
      push_event(8'h00, 32'h8000_0000);

      // random runs through the idling phases
      first_item = items_pushed;
      while (items_pushed < ITEM_STOP) begin
         phase = (items_pushed - first_item) * 4 / (ITEM_STOP - first_item);
         case (phase)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 88; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 88; end
            default: begin send_idle = 10; recv_stall = 10; end
         endcase
         route_run();
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("tb_route_sensor_progress_monitor_top: clean");
      else $display("tb_route_sensor_progress_monitor_top: errors");
      $finish;
   end

   // request driver; the expected outcome is queued when the beat is put up
   always @(posedge clock) begin
      request_type it;
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
               it = pending_q.pop_front();
               awaited_q.push_back(it.outcome);
               req_tvalid <= 1;
               req_tuser <= it.func;
               req_tdata <= it.data;
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // response monitor
   always @(posedge clock) begin
      outcome_type want, got;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[97:0];
            if (awaited_q.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, actual %0h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = awaited_q.pop_front();
               check_field("status", want.status, got.status);
               check_field("classification", want.cls, got.cls);
               check_field("expected_offset", want.exp_offset, got.exp_offset);
               check_field("expected_node", want.exp_node, got.exp_node);
               check_field("expected_next_offset", want.exp_next_offset, got.exp_next_offset);
               check_field("expected_next_node", want.exp_next_node, got.exp_next_node);
               check_field("matched_offset", want.matched_offset, got.matched_offset);
               check_field("matched_distance", want.matched_distance, got.matched_distance);
               check_field("missing_offset", want.missing_offset, got.missing_offset);
               check_field("gain_mm", want.gain_mm, got.gain_mm);
            end
         end
         rsp_tready <= $urandom_range(99) >= recv_stall;
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready) ||
             (pending_q.size() == 0 && awaited_q.size() == 0 && !csr_valid))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_route_sensor_progress_monitor_top: errors");
            $finish;
         end
      end
   end

endmodule
